FILE: src/brd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and register codes for the rggb demosaic block
package brd_pkg;

    localparam int PIX_W         = 8;
    localparam int WIN_ROWS      = 5;
    localparam int WIN_COLS      = 5;
    localparam int VIEW_COLS     = WIN_COLS + 1;
    localparam int LS_ROWS       = WIN_ROWS - 1;
    localparam int BANK_W        = $clog2(LS_ROWS);
    localparam int MAX_WIDTH_DEF = 2048;

    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 13;
    localparam int ROW_W       = 13;
    localparam int HLAST_W     = 12;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;

    localparam int MIN_SIZE   = 5;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd1280;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd720;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0]                pix_t;
    typedef logic [WIN_ROWS-1:0][PIX_W-1:0]  col_t;
    typedef col_t [WIN_COLS-1:0]             win_t;
    typedef col_t [VIEW_COLS-1:0]            view_t;
    typedef logic [LS_ROWS-1:0][PIX_W-1:0]   ls_rows_t;

    // position of the center pixel against the frame borders
    typedef struct packed {
        logic top0;
        logic top1;
        logic bot0;
        logic bot1;
        logic left0;
        logic left1;
        logic right0;
        logic right1;
        logic odd_r;
        logic odd_c;
    } edge_t;

endpackage

FILE: src/brd_line_store.sv
`timescale 1ns / 1ps
// four banked line stores with registered reads and row rotation
module brd_line_store
    import brd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int AW = $clog2(MAX_WIDTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [BANK_W-1:0] wbank,
    input  logic [AW-1:0]     waddr,
    input  pix_t              wdata,
    input  logic [AW-1:0]     raddr,
    input  logic [BANK_W-1:0] rot,
    output ls_rows_t          rows
);

    pix_t rd_all [LS_ROWS];

    genvar b;
    generate
        for (b = 0; b < LS_ROWS; b++)
        begin : g_bank
            pix_t mem [MAX_WIDTH];
            pix_t rd_reg;

            always_ff @(posedge clk)
            begin
                if (we && wbank == BANK_W'(b))
                begin
                    mem[waddr] <= wdata;
                end
                rd_reg <= mem[raddr];
            end

            assign rd_all[b] = rd_reg;
        end
    endgenerate

    // oldest row first: the bank being overwritten holds the row four up
    genvar i;
    generate
        for (i = 0; i < LS_ROWS; i++)
        begin : g_rot
            assign rows[i] = rd_all[rot + BANK_W'(i)];
        end
    endgenerate

endmodule

FILE: src/brd_kernel.sv
`timescale 1ns / 1ps
// edge-directed interpolation of one pixel from the clamped 5x5 neighborhood
module brd_kernel
    import brd_pkg::*;
(
    input  view_t view,
    input  edge_t edges,
    output pix_t  blue,
    output pix_t  green,
    output pix_t  red
);

    logic [2:0] ri_m2, ri_m1, ri_p1, ri_p2;
    logic [2:0] ci_m2, ci_m1, ci_p1, ci_p2;
    pix_t p, up, dn, lf, rt, uu, dd, ll, rr;
    pix_t d_ul, d_ur, d_dr, d_dl;
    pix_t gv, gh;
    logic [PIX_W:0]   sum_v, sum_h;
    logic [PIX_W+1:0] sum4, sum_d;
    pix_t mean_v, mean_h, mean4, mean_d;

    localparam logic [2:0] ROW_MID = 3'd2;
    localparam logic [2:0] COL_MID = 3'd3;

    // border replication: offsets past an edge fold back onto the edge pixel
    always_comb
    begin
        ri_m2 = edges.top0 ? ROW_MID : (edges.top1 ? ROW_MID - 3'd1 : ROW_MID - 3'd2);
        ri_m1 = edges.top0 ? ROW_MID : ROW_MID - 3'd1;
        ri_p1 = edges.bot0 ? ROW_MID : ROW_MID + 3'd1;
        ri_p2 = edges.bot0 ? ROW_MID : (edges.bot1 ? ROW_MID + 3'd1 : ROW_MID + 3'd2);
        ci_m2 = edges.left0 ? COL_MID : (edges.left1 ? COL_MID - 3'd1 : COL_MID - 3'd2);
        ci_m1 = edges.left0 ? COL_MID : COL_MID - 3'd1;
        ci_p1 = edges.right0 ? COL_MID : COL_MID + 3'd1;
        ci_p2 = edges.right0 ? COL_MID : (edges.right1 ? COL_MID + 3'd1 : COL_MID + 3'd2);
    end

    always_comb
    begin
        p    = view[COL_MID][ROW_MID];
        up   = view[COL_MID][ri_m1];
        dn   = view[COL_MID][ri_p1];
        lf   = view[ci_m1][ROW_MID];
        rt   = view[ci_p1][ROW_MID];
        uu   = view[COL_MID][ri_m2];
        dd   = view[COL_MID][ri_p2];
        ll   = view[ci_m2][ROW_MID];
        rr   = view[ci_p2][ROW_MID];
        d_ul = view[ci_m1][ri_m1];
        d_ur = view[ci_p1][ri_m1];
        d_dr = view[ci_p1][ri_p1];
        d_dl = view[ci_m1][ri_p1];
    end

    always_comb
    begin
        gv     = (uu > dd) ? uu - dd : dd - uu;
        gh     = (rr > ll) ? rr - ll : ll - rr;
        sum_v  = {1'b0, up} + {1'b0, dn};
        sum_h  = {1'b0, lf} + {1'b0, rt};
        sum4   = {1'b0, sum_v} + {1'b0, sum_h};
        sum_d  = {2'b00, d_ul} + {2'b00, d_ur} + {2'b00, d_dr} + {2'b00, d_dl};
        mean_v = sum_v[PIX_W:1];
        mean_h = sum_h[PIX_W:1];
        mean4  = sum4[PIX_W+1:2];
        mean_d = sum_d[PIX_W+1:2];
    end

    always_comb
    begin
        if (edges.odd_r == edges.odd_c)
        begin
            // red or blue site
            if (gv < gh)
            begin
                green = mean_v;
            end
            else if (gv > gh)
            begin
                green = mean_h;
            end
            else
            begin
                green = mean4;
            end
            if (!edges.odd_r)
            begin
                red  = p;
                blue = mean_d;
            end
            else
            begin
                blue = p;
                red  = mean_d;
            end
        end
        else
        begin
            green = p;
            if (!edges.odd_r)
            begin
                red  = mean_h;
                blue = mean_v;
            end
            else
            begin
                red  = mean_v;
                blue = mean_h;
            end
        end
    end

endmodule

FILE: src/bayer_rggb_demosaic.sv
`timescale 1ns / 1ps
// top level of the streaming rggb bayer demosaic
//
// raw samples enter in raster order on the input channel, one per transfer;
// each transfer gives at most one rgb result on the output channel.
// results lag the raw stream by two rows and two columns, so after the last
// raw sample of a frame the source sends 2*width + 2 drain transfers to
// flush the tail; end_of_frame marks the last pixel, after which a new frame
// starts. drain transfers that arrive before the frame is complete are
// dropped. a result is registered and appears in the cycle after the transfer
// that completes its neighborhood.
// throughput is one raw transfer per cycle: the line store banks take one
// write and one prefetch read per cycle, and the window and output register
// update in the same cycle. in_ready follows the single output register and
// cfg_valid, so input stops only while a result waits or a write is pending.
// reset clears the position counters and the window and loads width 1280
// and height 720; line store contents are undefined until a frame writes
// them. a configuration write restarts the frame at its first pixel.
module bayer_rggb_demosaic
    import brd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pix_t                   raw_pixel,
    input  logic                   drain,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pix_t                   blue,
    output pix_t                   green,
    output pix_t                   red,
    output logic                   end_of_frame,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [WIDTH_W-1:0]  image_width_reg, width_next;
    logic [HEIGHT_W-1:0] image_height_reg, height_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [AW-1:0]       col_reg, col_next;
    win_t                window_reg;
    logic                out_valid_reg, out_valid_next;
    pix_t                blue_reg, green_reg, red_reg;
    logic                eof_reg;

    logic [AW-1:0]      w_last;
    logic [HLAST_W-1:0] h_last;
    logic [ROW_W-1:0]   h_last_ext;
    logic [ROW_W-1:0]   rc;
    logic               cfg_fire, in_fire, step, produce;
    logic               col_is0, col_is1, col_is2, col_is3, x_lt2;
    logic               row_ge, in_frame, frame_done, ignore, eof;
    edge_t              edges;
    ls_rows_t           ls_rows;
    col_t               new_col;
    view_t              view;
    pix_t               k_blue, k_green, k_red;

    // effective frame size, saturated to the supported range
    always_comb
    begin
        if (image_width_reg < WIDTH_W'(MIN_SIZE))
        begin
            w_last = AW'(MIN_SIZE - 1);
        end
        else if (image_width_reg > MAX_WIDTH)
        begin
            w_last = AW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = AW'(image_width_reg - WIDTH_W'(1));
        end

        if (image_height_reg < HEIGHT_W'(MIN_SIZE))
        begin
            h_last = HLAST_W'(MIN_SIZE - 1);
        end
        else if (image_height_reg > HEIGHT_W'(MAX_HEIGHT))
        begin
            h_last = HLAST_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = HLAST_W'(image_height_reg - HEIGHT_W'(1));
        end
    end

    assign h_last_ext = {1'b0, h_last};

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = (!out_valid_reg || out_ready) && !cfg_valid;
    assign in_fire   = in_valid && in_ready;

    assign col_is0 = (col_reg == AW'(0));
    assign col_is1 = (col_reg == AW'(1));
    assign col_is2 = (col_reg == AW'(2));
    assign col_is3 = (col_reg == AW'(3));
    assign x_lt2   = col_is0 || col_is1;

    // at the first two columns the output is the tail of the row before
    assign rc       = row_reg - (x_lt2 ? ROW_W'(3) : ROW_W'(2));
    assign row_ge   = x_lt2 ? (row_reg >= ROW_W'(3)) : (row_reg >= ROW_W'(2));
    assign in_frame = row_ge && (rc <= h_last_ext);
    assign eof      = col_is1 && (rc == h_last_ext);

    assign frame_done = row_reg > h_last_ext;
    assign ignore     = drain && !frame_done;
    assign step       = in_fire && !ignore;
    assign produce    = step && in_frame;

    always_comb
    begin
        edges.top0   = (rc == ROW_W'(0));
        edges.top1   = (rc == ROW_W'(1));
        edges.bot0   = (rc == h_last_ext);
        edges.bot1   = (rc == h_last_ext - ROW_W'(1));
        edges.left0  = col_is2;
        edges.left1  = col_is3;
        edges.right0 = col_is1;
        edges.right1 = col_is0;
        edges.odd_r  = rc[0];
        edges.odd_c  = x_lt2 ? ~(w_last[0] ^ col_reg[0]) : col_reg[0];
    end

    brd_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (step),
        .wbank (row_reg[BANK_W-1:0]),
        .waddr (col_reg),
        .wdata (raw_pixel),
        .raddr (col_next),
        .rot   (row_reg[BANK_W-1:0]),
        .rows  (ls_rows)
    );

    assign new_col = {raw_pixel, ls_rows};
    assign view    = {new_col, window_reg};

    brd_kernel u_kernel (
        .view  (view),
        .edges (edges),
        .blue  (k_blue),
        .green (k_green),
        .red   (k_red)
    );

    always_comb
    begin
        width_next  = image_width_reg;
        height_next = image_height_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        if (cfg_fire)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
            row_next = '0;
            col_next = '0;
        end
        else if (step)
        begin
            if (produce && eof)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = produce;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
            row_reg          <= '0;
            col_reg          <= '0;
            out_valid_reg    <= 1'b0;
            window_reg       <= '0;
        end
        else
        begin
            image_width_reg  <= width_next;
            image_height_reg <= height_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            out_valid_reg    <= out_valid_next;
            if (step)
            begin
                window_reg <= view[VIEW_COLS-1:1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            blue_reg  <= k_blue;
            green_reg <= k_green;
            red_reg   <= k_red;
            eof_reg   <= eof;
        end
    end

    assign out_valid    = out_valid_reg;
    assign blue         = blue_reg;
    assign green        = green_reg;
    assign red          = red_reg;
    assign end_of_frame = eof_reg;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the streaming rggb bayer demosaic
module testbench;
    import brd_pkg::*;

    localparam int PERIOD       = 12;
    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 640;
    localparam int HOLDOFF      = 4;
    localparam int N_ROWS       = 22;

    typedef struct packed {
        pix_t blue;
        pix_t green;
        pix_t red;
        logic eof;
    } rgb_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_FLAT,
        ROW_RAND
    } row_kind_t;

    typedef enum int {
        TEX_FULL,
        TEX_FLATISH,
        TEX_BINARY
    } tex_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_reg_t              index;
        logic [CFG_DATA_W-1:0] data;
        logic [15:0]           count;
        logic                  drn;
        logic                  typed;
        pix_t                  tval;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    pix_t                   raw_pixel;
    logic                   drain;
    logic                   out_valid;
    logic                   out_ready;
    pix_t                   blue;
    pix_t                   green;
    pix_t                   red;
    logic                   end_of_frame;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // mirror of the block: line history, 5x5 neighborhood, position, sizes
    bit [PIX_W-1:0]     row_hist [4*MAX_W];
    bit [PIX_W-1:0]     nbhd [5][5];
    int                 next_row;
    int                 next_col;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    int                 cen_r;
    int                 cen_c;
    int                 cen_pos;
    int                 cur_w;
    int                 cur_h;

    rgb_t      pending_rgb [$];
    stim_row_t directed [N_ROWS];
    int        errors;
    int        counted_items;
    int        cycle_count;
    bit        idle_on;

    bayer_rggb_demosaic u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .raw_pixel    (raw_pixel),
        .drain        (drain),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .end_of_frame (end_of_frame),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int frame_w();
        int w;
        w = width_reg;
        return clamp_int(w, MIN_SIZE, MAX_W);
    endfunction

    function automatic int frame_h();
        int h;
        h = height_reg;
        return clamp_int(h, MIN_SIZE, MAX_HEIGHT);
    endfunction

    // sample at an offset from the current center, edges replicated
    function automatic int tap(int dr, int dc);
        int rr;
        int cc;
        rr = clamp_int(cen_r + dr, 0, cur_h - 1) - cen_r + 2;
        cc = clamp_int(cen_c + dc, 0, cur_w - 1) - cen_c + cen_pos;
        return nbhd[clamp_int(cc, 0, 4)][clamp_int(rr, 0, 4)];
    endfunction

    function automatic int absdiff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic rgb_t demosaic(int r, int c, int pos, int w, int h);
        int   p;
        int   up;
        int   rt;
        int   dn;
        int   lf;
        int   gv;
        int   gh;
        int   diag;
        int   vert;
        int   horz;
        rgb_t o;
        cen_r   = r;
        cen_c   = c;
        cen_pos = pos;
        cur_w   = w;
        cur_h   = h;
        p = tap(0, 0);
        o.eof = (r == h - 1) && (c == w - 1);
        if (r[0] == c[0])
        begin
            // red or blue site: green follows the flatter direction
            up = tap(-1, 0);
            rt = tap(0, 1);
            dn = tap(1, 0);
            lf = tap(0, -1);
            gv = absdiff(tap(-2, 0), tap(2, 0));
            gh = absdiff(tap(0, 2), tap(0, -2));
            diag = (tap(-1, -1) + tap(-1, 1) + tap(1, 1) + tap(1, -1)) / 4;
            if (gv < gh)
                o.green = pix_t'((up + dn) / 2);
            else if (gv > gh)
                o.green = pix_t'((lf + rt) / 2);
            else
                o.green = pix_t'((up + rt + dn + lf) / 4);
            if (r[0])
            begin
                o.blue = pix_t'(p);
                o.red  = pix_t'(diag);
            end
            else
            begin
                o.red  = pix_t'(p);
                o.blue = pix_t'(diag);
            end
        end
        else
        begin
            vert = (tap(-1, 0) + tap(1, 0)) / 2;
            horz = (tap(0, -1) + tap(0, 1)) / 2;
            o.green = pix_t'(p);
            if (r[0])
            begin
                o.red  = pix_t'(vert);
                o.blue = pix_t'(horz);
            end
            else
            begin
                o.red  = pix_t'(horz);
                o.blue = pix_t'(vert);
            end
        end
        return o;
    endfunction

    function automatic void push_column(int row, int col, pix_t pix);
        bit [PIX_W-1:0] v [5];
        int i;
        int j;
        for (i = 0; i < 4; i++)
            v[i] = row_hist[((row + i) & 3) * MAX_W + col];
        v[4] = pix;
        row_hist[(row & 3) * MAX_W + col] = pix;
        for (i = 0; i < 4; i++)
            for (j = 0; j < 5; j++)
                nbhd[i][j] = nbhd[i + 1][j];
        for (j = 0; j < 5; j++)
            nbhd[4][j] = v[j];
    endfunction

    // -1: dropped drain, 0: no pixel out, 1: one pixel out
    function automatic int predict_pixel(pix_t pix, logic drn, output rgb_t o);
        int w;
        int h;
        int rw;
        int x;
        int r;
        int c;
        int n;
        w  = frame_w();
        h  = frame_h();
        rw = next_row;
        x  = next_col;
        n  = 0;
        o  = '0;
        if (x >= w)
            x = w - 1;
        if (drn && rw < h)
            return -1;
        if (x < 2)
        begin
            // first two columns finish the tail of the row three above
            r = rw - 3;
            c = w - 2 + x;
            if (r >= 0 && r < h)
            begin
                o = demosaic(r, c, 3, w, h);
                n = 1;
            end
            push_column(rw, x, pix);
        end
        else
        begin
            push_column(rw, x, pix);
            r = rw - 2;
            c = x - 2;
            if (r >= 0 && r < h)
            begin
                o = demosaic(r, c, 2, w, h);
                n = 1;
            end
        end
        if (n == 1 && o.eof)
        begin
            next_row = 0;
            next_col = 0;
        end
        else
        begin
            x++;
            if (x >= w)
            begin
                x = 0;
                rw++;
            end
            next_row = rw & 'h1FFF;
            next_col = x & 'hFFF;
        end
        return n;
    endfunction

    function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = data[WIDTH_W-1:0];
        else
            height_reg = data[HEIGHT_W-1:0];
        next_row = 0;
        next_col = 0;
    endfunction

    function automatic pix_t rand_pix(tex_t tex);
        case (tex)
            TEX_FLATISH: return pix_t'($urandom_range(0, 3));
            TEX_BINARY:  return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default:     return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic stim_row_t mk_row(row_kind_t kind, cfg_reg_t index,
                                         logic [CFG_DATA_W-1:0] data, int count,
                                         logic drn, logic typed, pix_t tval);
        stim_row_t s;
        s.kind  = kind;
        s.index = index;
        s.data  = data;
        s.count = 16'(count);
        s.drn   = drn;
        s.typed = typed;
        s.tval  = tval;
        return s;
    endfunction

    // valid stays high after the transfer; an idle gap in the next call or a wait lowers it
    task automatic send_raw(pix_t pix, logic drn, logic typed, pix_t tval);
        int   gap;
        int   n;
        rgb_t o;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        raw_pixel <= pix;
        drain     <= drn;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        n = predict_pixel(pix, drn, o);
        if (n >= 0)
            counted_items++;
        if (n == 1)
        begin
            if (typed)
            begin
                o.blue  = tval;
                o.green = tval;
                o.red   = tval;
            end
            pending_rgb.push_back(o);
        end
    endtask

    task automatic wait_results(int holdoff);
        if (pending_rgb.size() != 0 || holdoff > 0)
        begin
            in_valid <= 1'b0;
            while (pending_rgb.size() != 0) @(posedge clk);
            repeat (holdoff) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    task automatic set_size(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata,
                            bit height_first);
        wait_results(HOLDOFF);
        if (height_first)
        begin
            write_reg(REG_IMAGE_HEIGHT, hdata);
            write_reg(REG_IMAGE_WIDTH, wdata);
        end
        else
        begin
            write_reg(REG_IMAGE_WIDTH, wdata);
            write_reg(REG_IMAGE_HEIGHT, hdata);
        end
        cfg_valid <= 1'b0;
    endtask

    // output side: random stall, then compare the transfer with the oldest pixel
    initial
    begin
        int   stall;
        rgb_t want;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            if (pending_rgb.size() == 0)
            begin
                $error("unexpected pixel: blue %0d green %0d red %0d end_of_frame %0b",
                       blue, green, red, end_of_frame);
                errors++;
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (blue !== want.blue)
                begin
                    $error("blue: expected %0d, got %0d", want.blue, blue);
                    errors++;
                end
                if (green !== want.green)
                begin
                    $error("green: expected %0d, got %0d", want.green, green);
                    errors++;
                end
                if (red !== want.red)
                begin
                    $error("red: expected %0d, got %0d", want.red, red);
                    errors++;
                end
                if (end_of_frame !== want.eof)
                begin
                    $error("end_of_frame: expected %0b, got %0b", want.eof, end_of_frame);
                    errors++;
                end
            end
            @(posedge clk);
        end
    end

    initial
    begin
        int                    i;
        int                    k;
        int                    f;
        int                    w;
        int                    h;
        int                    nfr;
        int                    npix;
        int                    start_items;
        bit                    broken;
        tex_t                  tex;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;

        in_valid   <= 1'b0;
        raw_pixel  <= '0;
        drain      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_IMAGE_WIDTH;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        errors        = 0;
        counted_items = 0;
        cycle_count   = 0;
        idle_on       = 1'b1;
        width_reg     = WIDTH_RST;
        height_reg    = HEIGHT_RST;
        next_row      = 0;
        next_col      = 0;

        // drains before the frame is complete are dropped
        directed[0]  = mk_row(ROW_FLAT, REG_IMAGE_WIDTH, 13'h000, 2, 1'b1, 1'b0, 8'h00);
        directed[1]  = mk_row(ROW_CFG, REG_IMAGE_WIDTH, 13'd5, 0, 1'b0, 1'b0, 8'h00);
        directed[2]  = mk_row(ROW_CFG, REG_IMAGE_HEIGHT, 13'd5, 0, 1'b0, 1'b0, 8'h00);
        // flat frames give the same value on every channel
        directed[3]  = mk_row(ROW_FLAT, REG_IMAGE_WIDTH, 13'h0FF, 25, 1'b0, 1'b1, 8'hFF);
        directed[4]  = mk_row(ROW_FLAT, REG_IMAGE_WIDTH, 13'h000, 12, 1'b1, 1'b1, 8'hFF);
        directed[5]  = mk_row(ROW_FLAT, REG_IMAGE_WIDTH, 13'h000, 3, 1'b1, 1'b0, 8'h00);
        directed[6]  = mk_row(ROW_FLAT, REG_IMAGE_WIDTH, 13'h000, 25, 1'b0, 1'b1, 8'h00);
        // raw samples past the frame end flush like drains
        directed[7]  = mk_row(ROW_FLAT, REG_IMAGE_WIDTH, 13'h0A5, 12, 1'b0, 1'b1, 8'h00);
        directed[8]  = mk_row(ROW_RAND, REG_IMAGE_WIDTH, 13'h000, 25, 1'b0, 1'b0, 8'h00);
        directed[9]  = mk_row(ROW_RAND, REG_IMAGE_WIDTH, 13'h000, 12, 1'b1, 1'b0, 8'h00);
        // partial frame, then a register write drops it
        directed[10] = mk_row(ROW_RAND, REG_IMAGE_WIDTH, 13'h000, 13, 1'b0, 1'b0, 8'h00);
        directed[11] = mk_row(ROW_CFG, REG_IMAGE_WIDTH, 13'd0, 0, 1'b0, 1'b0, 8'h00);
        directed[12] = mk_row(ROW_CFG, REG_IMAGE_HEIGHT, 13'h1FFF, 0, 1'b0, 1'b0, 8'h00);
        directed[13] = mk_row(ROW_RAND, REG_IMAGE_WIDTH, 13'h000, 30, 1'b0, 1'b0, 8'h00);
        // top bit of the width write is not part of the register
        directed[14] = mk_row(ROW_CFG, REG_IMAGE_WIDTH, 13'h1006, 0, 1'b0, 1'b0, 8'h00);
        directed[15] = mk_row(ROW_CFG, REG_IMAGE_HEIGHT, 13'd6, 0, 1'b0, 1'b0, 8'h00);
        directed[16] = mk_row(ROW_RAND, REG_IMAGE_WIDTH, 13'h000, 36, 1'b0, 1'b0, 8'h00);
        directed[17] = mk_row(ROW_RAND, REG_IMAGE_WIDTH, 13'h000, 14, 1'b1, 1'b0, 8'h00);
        directed[18] = mk_row(ROW_FLAT, REG_IMAGE_WIDTH, 13'h080, 2, 1'b1, 1'b0, 8'h00);
        directed[19] = mk_row(ROW_CFG, REG_IMAGE_HEIGHT, 13'd7, 0, 1'b0, 1'b0, 8'h00);
        directed[20] = mk_row(ROW_RAND, REG_IMAGE_WIDTH, 13'h000, 42, 1'b0, 1'b0, 8'h00);
        directed[21] = mk_row(ROW_RAND, REG_IMAGE_WIDTH, 13'h000, 14, 1'b1, 1'b0, 8'h00);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_ROWS; i++)
        begin
            case (directed[i].kind)
                ROW_CFG:
                begin
                    wait_results(HOLDOFF);
                    write_reg(directed[i].index, directed[i].data);
                    cfg_valid <= 1'b0;
                end
                ROW_FLAT:
                    for (k = 0; k < directed[i].count; k++)
                        send_raw(directed[i].data[PIX_W-1:0], directed[i].drn,
                                 directed[i].typed, directed[i].tval);
                default:
                    for (k = 0; k < directed[i].count; k++)
                        send_raw(rand_pix(TEX_FULL), directed[i].drn, 1'b0, 8'h00);
            endcase
        end

        start_items = counted_items;
        while (counted_items - start_items < RANDOM_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            w = $urandom_range(5, 12);
            h = $urandom_range(5, 8);
            wdata = CFG_DATA_W'(w);
            hdata = CFG_DATA_W'(h);
            case ($urandom_range(0, 9))
                0:
                begin
                    wdata = CFG_DATA_W'($urandom_range(0, 4));
                    w = MIN_SIZE;
                end
                1:
                begin
                    hdata = CFG_DATA_W'($urandom_range(0, 4));
                    h = MIN_SIZE;
                end
                2: wdata = wdata | 13'h1000;
                default: ;
            endcase
            set_size(wdata, hdata, 1'($urandom_range(0, 1)));
            nfr = $urandom_range(1, 2);
            for (f = 0; f < nfr; f++)
            begin
                tex = tex_t'($urandom_range(0, 2));
                broken = ($urandom_range(0, 9) == 0);
                npix = broken ? $urandom_range(1, w * h) : w * h;
                for (k = 0; k < npix; k++)
                begin
                    if ($urandom_range(0, 31) == 0)
                        send_raw(rand_pix(TEX_FULL), 1'b1, 1'b0, 8'h00);
                    // sender holds off until the output side has caught up
                    if ($urandom_range(0, 199) == 0)
                        wait_results(0);
                    send_raw(rand_pix(tex), 1'b0, 1'b0, 8'h00);
                end
                if (broken)
                    break;
                // flush mixes drains with raw samples past the frame end
                for (k = 0; k < 2 * w + 2; k++)
                    send_raw(rand_pix(TEX_FULL), ($urandom_range(0, 4) != 0), 1'b0, 8'h00);
            end
        end

        wait_results(HOLDOFF);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
